/* hdl/mrg_pkg.sv */
// ----------------------------------------------------------------------------
// Motor reversal guard package
// Shared types, register indexes and codes of the motor reversal guard.
// ----------------------------------------------------------------------------
package mrg_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_REVERSE_DELAY_TICKS    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OVERCURRENT_LEVEL      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OVERCURRENT_TICK_LIMIT = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RUN_TIME_LIMIT         = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DRIVE_DUTY             = 3'd4;

  localparam logic [15:0] RST_REVERSE_DELAY_TICKS    = 16'd100;
  localparam logic [11:0] RST_OVERCURRENT_LEVEL      = 12'd3000;
  localparam logic [15:0] RST_OVERCURRENT_TICK_LIMIT = 16'd50;
  localparam logic [31:0] RST_RUN_TIME_LIMIT         = 32'd60000;
  localparam logic [15:0] RST_DRIVE_DUTY             = 16'd1000;

  localparam logic MODE_TICK    = 1'b0;
  localparam logic MODE_SET_DIR = 1'b1;

  localparam logic [1:0] DIR_TOGGLE  = 2'd0;
  localparam logic [1:0] DIR_FORWARD = 2'd1;
  localparam logic [1:0] DIR_REVERSE = 2'd2;
  localparam logic [1:0] DIR_INVALID = 2'd3;
  localparam logic [1:0] DIR_NONE    = 2'd0;

  localparam logic [1:0] STATUS_STOPPED = 2'd0;
  localparam logic [1:0] STATUS_FORWARD = 2'd1;
  localparam logic [1:0] STATUS_REVERSE = 2'd2;

  localparam logic [1:0] LAMP_LEAVE = 2'd0;
  localparam logic [1:0] LAMP_OFF   = 2'd1;
  localparam logic [1:0] LAMP_ON    = 2'd2;

  typedef struct packed {
    logic [15:0] reverse_delay_ticks;
    logic [11:0] overcurrent_level;
    logic [15:0] overcurrent_tick_limit;
    logic [31:0] run_time_limit;
    logic [15:0] drive_duty;
  } cfg_t;

  typedef struct packed {
    logic                   mode;
    logic [1:0]             dir_request;
    logic                   fwd_sample_valid;
    logic [SAMPLE_BITS-1:0] fwd_sample;
    logic                   rev_sample_valid;
    logic [SAMPLE_BITS-1:0] rev_sample;
  } item_t;

  typedef struct packed {
    logic [15:0] fwd_duty;
    logic [15:0] rev_duty;
    logic [1:0]  run_status;
    logic [1:0]  lamp_command;
    logic        fault_stop;
    logic        change_pending;
  } result_t;

endpackage

/* hdl/mrg_in_if.sv */
// ----------------------------------------------------------------------------
// Motor reversal guard request channel
// Valid/ready channel that carries one tick or set-direction request.
// ----------------------------------------------------------------------------
interface mrg_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [1:0]  dir_request;
  logic        fwd_sample_valid;
  logic [11:0] fwd_sample;
  logic        rev_sample_valid;
  logic [11:0] rev_sample;

  modport source (
    output valid, mode, dir_request, fwd_sample_valid, fwd_sample,
    output rev_sample_valid, rev_sample,
    input  ready
  );
  modport sink (
    input  valid, mode, dir_request, fwd_sample_valid, fwd_sample,
    input  rev_sample_valid, rev_sample,
    output ready
  );
endinterface

/* hdl/mrg_out_if.sv */
// ----------------------------------------------------------------------------
// Motor reversal guard result channel
// Valid/ready channel that carries the drive outputs for one request.
// ----------------------------------------------------------------------------
interface mrg_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] fwd_duty;
  logic [15:0] rev_duty;
  logic [1:0]  run_status;
  logic [1:0]  lamp_command;
  logic        fault_stop;
  logic        change_pending;

  modport source (
    output valid, fwd_duty, rev_duty, run_status, lamp_command, fault_stop,
    output change_pending,
    input  ready
  );
  modport sink (
    input  valid, fwd_duty, rev_duty, run_status, lamp_command, fault_stop,
    input  change_pending,
    output ready
  );
endinterface

/* hdl/mrg_cfg_if.sv */
// ----------------------------------------------------------------------------
// Motor reversal guard configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface mrg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [31:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

/* hdl/mrg_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Motor reversal guard configuration registers
// Holds the delay, current, limit and duty settings written over the port.
// ----------------------------------------------------------------------------
module mrg_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [mrg_pkg::CFG_INDEX_BITS-1:0]  wr_index,
  input  logic [mrg_pkg::CFG_DATA_BITS-1:0]   wr_data,
  output mrg_pkg::cfg_t                       cfg
);
  import mrg_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reverse_delay_ticks    <= RST_REVERSE_DELAY_TICKS;
      cfg_r.overcurrent_level      <= RST_OVERCURRENT_LEVEL;
      cfg_r.overcurrent_tick_limit <= RST_OVERCURRENT_TICK_LIMIT;
      cfg_r.run_time_limit         <= RST_RUN_TIME_LIMIT;
      cfg_r.drive_duty             <= RST_DRIVE_DUTY;
    end else if (wr_en) begin
      case (wr_index)
        REG_REVERSE_DELAY_TICKS:    cfg_r.reverse_delay_ticks    <= wr_data[15:0];
        REG_OVERCURRENT_LEVEL:      cfg_r.overcurrent_level      <= wr_data[11:0];
        REG_OVERCURRENT_TICK_LIMIT: cfg_r.overcurrent_tick_limit <= wr_data[15:0];
        REG_RUN_TIME_LIMIT:         cfg_r.run_time_limit         <= wr_data[31:0];
        REG_DRIVE_DUTY:             cfg_r.drive_duty             <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* hdl/mrg_core.sv */
// ----------------------------------------------------------------------------
// Motor reversal guard control core
// Direction target, change delay, current and run-time guard state with
// the single-pass update and result for one request.
// ----------------------------------------------------------------------------
module mrg_core #(
  parameter int ADC_BITS = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  mrg_pkg::item_t    item,
  input  mrg_pkg::cfg_t     cfg,
  output mrg_pkg::result_t  result
);
  import mrg_pkg::*;

  localparam int SAMPLE_W = (ADC_BITS < SAMPLE_BITS) ? ADC_BITS : SAMPLE_BITS;

  logic [1:0]          target_r, target_nxt;
  logic [1:0]          motor_r, motor_nxt;
  logic                armed_r, armed_nxt;
  logic [15:0]         delay_r, delay_nxt;
  logic [SAMPLE_W-1:0] last_fwd_r, last_fwd_nxt;
  logic [SAMPLE_W-1:0] last_rev_r, last_rev_nxt;
  logic [15:0]         oc_count_r, oc_count_nxt;
  logic [31:0]         run_count_r, run_count_nxt;

  logic [1:0]          lamp;
  logic                fault;
  logic [SAMPLE_W-1:0] level;
  logic [SAMPLE_W-1:0] sample;

  assign level = cfg.overcurrent_level[SAMPLE_W-1:0];

  always_comb begin
    target_nxt    = target_r;
    motor_nxt     = motor_r;
    armed_nxt     = armed_r;
    delay_nxt     = delay_r;
    last_fwd_nxt  = last_fwd_r;
    last_rev_nxt  = last_rev_r;
    oc_count_nxt  = oc_count_r;
    run_count_nxt = run_count_r;
    lamp          = LAMP_LEAVE;
    fault         = 1'b0;
    sample        = last_rev_r;

    if (item.mode == MODE_SET_DIR) begin
      if (item.dir_request != DIR_INVALID && item.dir_request != target_r) begin
        motor_nxt = STATUS_STOPPED;
        if (item.dir_request == DIR_TOGGLE) begin
          target_nxt = (target_r == DIR_FORWARD) ? DIR_REVERSE : DIR_FORWARD;
        end else begin
          target_nxt = item.dir_request;
        end
        delay_nxt = cfg.reverse_delay_ticks;
        armed_nxt = 1'b1;
      end
    end else begin
      if (armed_r && delay_r != 16'd0) begin
        delay_nxt = delay_r - 16'd1;
      end
      if (armed_r && delay_nxt == 16'd0) begin
        armed_nxt = 1'b0;
        motor_nxt = (target_r == DIR_FORWARD) ? STATUS_FORWARD : STATUS_REVERSE;
      end
      if (motor_nxt != STATUS_STOPPED) begin
        lamp = LAMP_OFF;
      end

      if (item.fwd_sample_valid) begin
        last_fwd_nxt = item.fwd_sample[SAMPLE_W-1:0];
      end
      if (item.rev_sample_valid) begin
        last_rev_nxt = item.rev_sample[SAMPLE_W-1:0];
      end

      sample = (motor_nxt == STATUS_FORWARD) ? last_fwd_nxt : last_rev_nxt;
      if (motor_nxt == STATUS_FORWARD || motor_nxt == STATUS_REVERSE) begin
        if (sample > level) begin
          oc_count_nxt = (&oc_count_r) ? oc_count_r : oc_count_r + 16'd1;
        end else begin
          oc_count_nxt = 16'd0;
        end
        run_count_nxt = (&run_count_r) ? run_count_r : run_count_r + 32'd1;
      end else begin
        oc_count_nxt  = 16'd0;
        run_count_nxt = 32'd0;
      end

      if (oc_count_nxt > cfg.overcurrent_tick_limit || run_count_nxt > cfg.run_time_limit) begin
        motor_nxt = STATUS_STOPPED;
        fault     = 1'b1;
        if (target_r == DIR_FORWARD) begin
          lamp = LAMP_ON;
        end
      end
    end

    result.fwd_duty       = (motor_nxt == STATUS_FORWARD) ? cfg.drive_duty : 16'd0;
    result.rev_duty       = (motor_nxt == STATUS_REVERSE) ? cfg.drive_duty : 16'd0;
    result.run_status     = motor_nxt;
    result.lamp_command   = lamp;
    result.fault_stop     = fault;
    result.change_pending = armed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= DIR_NONE;
      motor_r     <= STATUS_STOPPED;
      armed_r     <= 1'b0;
      delay_r     <= 16'd0;
      last_fwd_r  <= '0;
      last_rev_r  <= '0;
      oc_count_r  <= 16'd0;
      run_count_r <= 32'd0;
    end else if (step_en) begin
      target_r    <= target_nxt;
      motor_r     <= motor_nxt;
      armed_r     <= armed_nxt;
      delay_r     <= delay_nxt;
      last_fwd_r  <= last_fwd_nxt;
      last_rev_r  <= last_rev_nxt;
      oc_count_r  <= oc_count_nxt;
      run_count_r <= run_count_nxt;
    end
  end

endmodule

/* hdl/motor_reversal_guard_controller.sv */
// ----------------------------------------------------------------------------
// Motor reversal guard controller
// H-bridge direction controller with a reversal delay and an over-current
// and run-time guard; one result for every request.
// The result of a request is registered and presented in the cycle after acceptance.
// Throughput: one request per cycle, set by the single result register that
// accepts a new request whenever it is empty or being drained.
// Reset: synchronous; clears the direction, delay and guard state and loads
// the default settings. No request is taken during reset.
// ----------------------------------------------------------------------------
module motor_reversal_guard_controller #(
  parameter int ADC_BITS = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  mrg_in_if.sink     in_ch,
  mrg_out_if.source  out_ch,
  mrg_cfg_if.sink    cfg_ch
);
  import mrg_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t result;
  result_t result_r;
  logic    out_valid_r;
  logic    in_accept;

  assign cfg_ch.ready = 1'b1;

  mrg_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.reg_index),
    .wr_data  (cfg_ch.wdata),
    .cfg      (cfg)
  );

  assign item.mode             = in_ch.mode;
  assign item.dir_request      = in_ch.dir_request;
  assign item.fwd_sample_valid = in_ch.fwd_sample_valid;
  assign item.fwd_sample       = in_ch.fwd_sample;
  assign item.rev_sample_valid = in_ch.rev_sample_valid;
  assign item.rev_sample       = in_ch.rev_sample;

  assign in_ch.ready = rst_n && (!out_valid_r || out_ch.ready);
  assign in_accept   = in_ch.valid && in_ch.ready;

  mrg_core #(
    .ADC_BITS (ADC_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_accept),
    .item    (item),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      result_r <= result;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.fwd_duty       = result_r.fwd_duty;
  assign out_ch.rev_duty       = result_r.rev_duty;
  assign out_ch.run_status     = result_r.run_status;
  assign out_ch.lamp_command   = result_r.lamp_command;
  assign out_ch.fault_stop     = result_r.fault_stop;
  assign out_ch.change_pending = result_r.change_pending;

  // A fault stop always leaves the motor stopped.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && result_r.fault_stop) |-> (result_r.run_status == STATUS_STOPPED))
    else $error("fault stop reported while the motor runs");

  // The motor never drives while a direction change is still pending.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && result_r.change_pending) |-> (result_r.run_status == STATUS_STOPPED))
    else $error("motor drives during a pending direction change");

  // The lamp is only switched on by a fault stop.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && result_r.lamp_command == LAMP_ON) |-> result_r.fault_stop)
    else $error("lamp switched on without a fault stop");

  // The forward leg carries a duty value only while the motor runs forward.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && result_r.run_status != STATUS_FORWARD) |-> (result_r.fwd_duty == 16'd0))
    else $error("forward duty applied while not running forward");

  // No request is taken while an undelivered result is held.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !in_accept)
    else $error("request accepted over an undelivered result");

endmodule

/* dv/mrg_drive_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor reversal guard drive checker
// Watches the request, result and configuration channels of the controller.
// It keeps its own copy of the settings and of the direction, delay and guard
// state. For every accepted request it works out the expected drive outputs.
// Each result that comes out is compared, field by field, with the oldest
// expected one.
// ----------------------------------------------------------------------------
module mrg_drive_checker #(
  parameter int ADC_BITS = 12
) (
  input  logic clk,
  input  logic rst_n,
  mrg_in_if    in_ch,
  mrg_out_if   out_ch,
  mrg_cfg_if   cfg_ch,
  output int   mismatch_count,
  output int   pending_results
);
  import mrg_pkg::*;

  localparam logic [SAMPLE_BITS-1:0] ADC_MASK = SAMPLE_BITS'((1 << ADC_BITS) - 1);

  cfg_t                   settings;
  logic [1:0]             target_dir;
  logic [1:0]             motor_state;
  logic                   change_armed;
  logic [15:0]            delay_left;
  logic [SAMPLE_BITS-1:0] fwd_latch;
  logic [SAMPLE_BITS-1:0] rev_latch;
  logic [15:0]            overcurrent_run;
  logic [31:0]            running_ticks;
  result_t                expected_drive[$];

  task automatic load_defaults();
    settings.reverse_delay_ticks    = RST_REVERSE_DELAY_TICKS;
    settings.overcurrent_level      = RST_OVERCURRENT_LEVEL;
    settings.overcurrent_tick_limit = RST_OVERCURRENT_TICK_LIMIT;
    settings.run_time_limit         = RST_RUN_TIME_LIMIT;
    settings.drive_duty             = RST_DRIVE_DUTY;
    target_dir      = DIR_NONE;
    motor_state     = STATUS_STOPPED;
    change_armed    = 1'b0;
    delay_left      = '0;
    fwd_latch       = '0;
    rev_latch       = '0;
    overcurrent_run = '0;
    running_ticks   = '0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    end
  endtask

  task automatic predict_drive(input item_t req, output result_t res);
    logic [1:0]             lamp;
    logic                   fault;
    logic [SAMPLE_BITS-1:0] level;
    logic [SAMPLE_BITS-1:0] leg;
    lamp  = LAMP_LEAVE;
    fault = 1'b0;
    level = settings.overcurrent_level & ADC_MASK;
    if (req.mode == MODE_SET_DIR) begin
      if (req.dir_request != DIR_INVALID && req.dir_request != target_dir) begin
        motor_state = STATUS_STOPPED;
        if (req.dir_request == DIR_TOGGLE) begin
          target_dir = (target_dir == DIR_FORWARD) ? DIR_REVERSE : DIR_FORWARD;
        end else begin
          target_dir = req.dir_request;
        end
        delay_left   = settings.reverse_delay_ticks;
        change_armed = 1'b1;
      end
    end else begin
      if (change_armed && delay_left != 16'd0) begin
        delay_left--;
      end
      if (change_armed && delay_left == 16'd0) begin
        change_armed = 1'b0;
        if (target_dir == DIR_FORWARD) begin
          motor_state = STATUS_FORWARD;
        end else begin
          motor_state = STATUS_REVERSE;
          lamp        = LAMP_OFF;
        end
      end
      if (motor_state != STATUS_STOPPED) begin
        lamp = LAMP_OFF;
      end
      if (req.fwd_sample_valid) begin
        fwd_latch = req.fwd_sample & ADC_MASK;
      end
      if (req.rev_sample_valid) begin
        rev_latch = req.rev_sample & ADC_MASK;
      end
      if (motor_state == STATUS_FORWARD || motor_state == STATUS_REVERSE) begin
        leg = (motor_state == STATUS_FORWARD) ? fwd_latch : rev_latch;
        if (leg > level) begin
          if (overcurrent_run != 16'hFFFF) begin
            overcurrent_run++;
          end
        end else begin
          overcurrent_run = '0;
        end
        if (running_ticks != 32'hFFFF_FFFF) begin
          running_ticks++;
        end
      end else begin
        overcurrent_run = '0;
        running_ticks   = '0;
      end
      if (overcurrent_run > settings.overcurrent_tick_limit ||
          running_ticks > settings.run_time_limit) begin
        motor_state = STATUS_STOPPED;
        fault       = 1'b1;
        if (target_dir == DIR_FORWARD) begin
          lamp = LAMP_ON;
        end
      end
    end
    res.fwd_duty       = (motor_state == STATUS_FORWARD) ? settings.drive_duty : 16'd0;
    res.rev_duty       = (motor_state == STATUS_REVERSE) ? settings.drive_duty : 16'd0;
    res.run_status     = motor_state;
    res.lamp_command   = lamp;
    res.fault_stop     = fault;
    res.change_pending = change_armed;
  endtask

  always @(posedge clk) begin : watch
    item_t   req;
    result_t got;
    result_t want;
    if (!rst_n) begin
      load_defaults();
      expected_drive.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          REG_REVERSE_DELAY_TICKS:    settings.reverse_delay_ticks    = cfg_ch.wdata[15:0];
          REG_OVERCURRENT_LEVEL:      settings.overcurrent_level      = cfg_ch.wdata[11:0];
          REG_OVERCURRENT_TICK_LIMIT: settings.overcurrent_tick_limit = cfg_ch.wdata[15:0];
          REG_RUN_TIME_LIMIT:         settings.run_time_limit         = cfg_ch.wdata;
          REG_DRIVE_DUTY:             settings.drive_duty             = cfg_ch.wdata[15:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got.fwd_duty       = out_ch.fwd_duty;
        got.rev_duty       = out_ch.rev_duty;
        got.run_status     = out_ch.run_status;
        got.lamp_command   = out_ch.lamp_command;
        got.fault_stop     = out_ch.fault_stop;
        got.change_pending = out_ch.change_pending;
        if (expected_drive.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          want = expected_drive.pop_front();
          check_field("fwd_duty", 32'(got.fwd_duty), 32'(want.fwd_duty));
          check_field("rev_duty", 32'(got.rev_duty), 32'(want.rev_duty));
          check_field("run_status", 32'(got.run_status), 32'(want.run_status));
          check_field("lamp_command", 32'(got.lamp_command), 32'(want.lamp_command));
          check_field("fault_stop", 32'(got.fault_stop), 32'(want.fault_stop));
          check_field("change_pending", 32'(got.change_pending),
                      32'(want.change_pending));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        req.mode             = in_ch.mode;
        req.dir_request      = in_ch.dir_request;
        req.fwd_sample_valid = in_ch.fwd_sample_valid;
        req.fwd_sample       = in_ch.fwd_sample;
        req.rev_sample_valid = in_ch.rev_sample_valid;
        req.rev_sample       = in_ch.rev_sample;
        predict_drive(req, want);
        expected_drive.push_back(want);
      end
    end
    pending_results <= expected_drive.size();
  end

endmodule

/* dv/tb_motor_reversal_guard_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor reversal guard controller testbench
// Drives direction and tick requests, with random gaps, into the controller.
// The result side stalls at random. Between phases the settings are
// rewritten, the extremes among them. A separate checker predicts and
// compares every result. This module makes the stimulus and gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_motor_reversal_guard_controller;
  import mrg_pkg::*;

  localparam int ADC_BITS = SAMPLE_BITS;

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   pending_results;

  mrg_in_if  in_ch();
  mrg_out_if out_ch();
  mrg_cfg_if cfg_ch();

  motor_reversal_guard_controller #(.ADC_BITS(ADC_BITS)) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  mrg_drive_checker #(.ADC_BITS(ADC_BITS)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_ch         (cfg_ch),
    .mismatch_count (mismatch_count),
    .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #8ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic int stall_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) begin
      return $urandom_range(1, 3);
    end else if (roll < 95) begin
      return $urandom_range(4, 8);
    end else begin
      return $urandom_range(20, 40);
    end
  endfunction

  function automatic int request_gap();
    if ($urandom_range(0, 99) < 60) begin
      return 0;
    end
    return stall_length();
  endfunction

  initial begin : result_ready
    int stall_left;
    int calm_left;
    int roll;
    stall_left = 0;
    calm_left  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (calm_left > 0) begin
        calm_left--;
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          stall_left = stall_length();
        end else if (roll < 12) begin
          calm_left = $urandom_range(30, 80);
        end
      end
    end
  end

  function automatic item_t tick_req(input logic fv, input logic [11:0] fs,
                                     input logic rv, input logic [11:0] rs);
    item_t r;
    r.mode             = MODE_TICK;
    r.dir_request      = DIR_TOGGLE;
    r.fwd_sample_valid = fv;
    r.fwd_sample       = fs;
    r.rev_sample_valid = rv;
    r.rev_sample       = rs;
    return r;
  endfunction

  function automatic item_t dir_req(input logic [1:0] dir);
    item_t r;
    r = tick_req(1'b1, 12'hFFF, 1'b1, 12'hFFF);
    r.mode        = MODE_SET_DIR;
    r.dir_request = dir;
    return r;
  endfunction

  function automatic logic [11:0] random_sample(input logic [11:0] level);
    int roll;
    int v;
    roll = $urandom_range(0, 99);
    if (roll < 20) begin
      return 12'hFFF;
    end else if (roll < 30) begin
      return 12'h000;
    end else if (roll < 60) begin
      return 12'($urandom);
    end
    v = int'(level) + $urandom_range(0, 11) - 3;
    if (v < 0) begin
      v = 0;
    end else if (v > 4095) begin
      v = 4095;
    end
    return 12'(v);
  endfunction

  function automatic item_t random_request(input logic [11:0] level);
    item_t r;
    int    roll;
    r.mode = ($urandom_range(0, 99) < 18) ? MODE_SET_DIR : MODE_TICK;
    roll = $urandom_range(0, 99);
    r.dir_request = (roll < 35) ? DIR_FORWARD :
                    (roll < 70) ? DIR_REVERSE :
                    (roll < 92) ? DIR_TOGGLE : DIR_INVALID;
    r.fwd_sample_valid = ($urandom_range(0, 99) < 45);
    r.fwd_sample       = random_sample(level);
    r.rev_sample_valid = ($urandom_range(0, 99) < 45);
    r.rev_sample       = random_sample(level);
    return r;
  endfunction

  task automatic send_request(input item_t req, input int gap);
    in_ch.valid            <= 1'b1;
    in_ch.mode             <= req.mode;
    in_ch.dir_request      <= req.dir_request;
    in_ch.fwd_sample_valid <= req.fwd_sample_valid;
    in_ch.fwd_sample       <= req.fwd_sample;
    in_ch.rev_sample_valid <= req.rev_sample_valid;
    in_ch.rev_sample       <= req.rev_sample;
    do @(posedge clk); while (!in_ch.ready);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input cfg_t s);
    wait_drained();
    write_reg(REG_REVERSE_DELAY_TICKS, {16'd0, s.reverse_delay_ticks});
    write_reg(REG_OVERCURRENT_LEVEL, {20'd0, s.overcurrent_level});
    write_reg(REG_OVERCURRENT_TICK_LIMIT, {16'd0, s.overcurrent_tick_limit});
    write_reg(REG_RUN_TIME_LIMIT, s.run_time_limit);
    write_reg(REG_DRIVE_DUTY, {16'd0, s.drive_duty});
  endtask

  task automatic run_random_phase(input cfg_t s, input int count, input bit hold_midway);
    apply_settings(s);
    for (int i = 0; i < count; i++) begin
      if (hold_midway && i == count / 2) begin
        wait_drained();
      end
      send_request(random_request(s.overcurrent_level), request_gap());
    end
  endtask

  initial begin : stimulus
    cfg_t s;
    rst_n                  <= 1'b0;
    in_ch.valid            <= 1'b0;
    in_ch.mode             <= MODE_TICK;
    in_ch.dir_request      <= DIR_TOGGLE;
    in_ch.fwd_sample_valid <= 1'b0;
    in_ch.fwd_sample       <= '0;
    in_ch.rev_sample_valid <= 1'b0;
    in_ch.rev_sample       <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.reg_index       <= REG_REVERSE_DELAY_TICKS;
    cfg_ch.wdata           <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(tick_req(1'b0, 12'h000, 1'b0, 12'h000), 0);
    send_request(dir_req(DIR_TOGGLE), 0);
    send_request(dir_req(DIR_INVALID), 1);
    send_request(dir_req(DIR_FORWARD), 0);
    send_request(dir_req(DIR_FORWARD), 0);
    send_request(tick_req(1'b1, 12'hFFF, 1'b1, 12'hFFF), 2);
    send_request(tick_req(1'b0, 12'hFFF, 1'b0, 12'h000), 0);

    s = '{reverse_delay_ticks: 16'd0, overcurrent_level: 12'd2000,
          overcurrent_tick_limit: 16'd2, run_time_limit: 32'hFFFF_FFFF,
          drive_duty: 16'hFFFF};
    apply_settings(s);
    send_request(dir_req(DIR_REVERSE), 0);
    send_request(tick_req(1'b0, 12'h000, 1'b0, 12'h000), 0);
    send_request(tick_req(1'b1, 12'h000, 1'b1, 12'hFFF), 0);
    send_request(tick_req(1'b0, 12'h000, 1'b0, 12'h000), 1);
    send_request(dir_req(DIR_TOGGLE), 0);
    send_request(tick_req(1'b1, 12'hFFF, 1'b0, 12'h000), 0);
    send_request(tick_req(1'b0, 12'h000, 1'b0, 12'h000), 0);
    send_request(tick_req(1'b0, 12'h000, 1'b0, 12'h000), 0);
    send_request(dir_req(DIR_REVERSE), 0);
    send_request(dir_req(DIR_TOGGLE), 0);
    send_request(tick_req(1'b1, 12'h000, 1'b1, 12'h000), 0);

    s = '{reverse_delay_ticks: 16'd3, overcurrent_level: 12'hFFF,
          overcurrent_tick_limit: 16'd0, run_time_limit: 32'd0,
          drive_duty: 16'd0};
    apply_settings(s);
    send_request(dir_req(DIR_REVERSE), 0);
    repeat (4) send_request(tick_req(1'b1, 12'hFFF, 1'b1, 12'hFFF), 0);

    s = '{reverse_delay_ticks: 16'd0, overcurrent_level: 12'd0,
          overcurrent_tick_limit: 16'hFFFF, run_time_limit: 32'hFFFF_FFFF,
          drive_duty: 16'hFFFF};
    run_random_phase(s, 120, 1'b0);

    s = '{reverse_delay_ticks: 16'hFFFF, overcurrent_level: 12'hFFF,
          overcurrent_tick_limit: 16'd0, run_time_limit: 32'd0,
          drive_duty: 16'd0};
    run_random_phase(s, 40, 1'b0);

    for (int p = 0; p < 4; p++) begin
      s.reverse_delay_ticks    = 16'($urandom_range(0, 4));
      s.overcurrent_level      = 12'($urandom_range(0, 4095));
      s.overcurrent_tick_limit = 16'($urandom_range(0, 6));
      s.run_time_limit         = 32'($urandom_range(2, 40));
      s.drive_duty             = 16'($urandom_range(0, 65535));
      run_random_phase(s, 120, p == 0);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
